### sv/utf8enc_pkg.sv
// Shared types, constants and the code point encoder of the UTF-8 encoder.
package utf8enc_pkg;

   localparam int MaxBytes = 6;
   localparam int CountW = 3;

   localparam logic [31:0] CP_MAX = 32'h0010_FFFF;
   localparam logic [31:0] SURR_FIRST = 32'h0000_D800;
   localparam logic [31:0] SURR_LAST = 32'h0000_DFFF;
   localparam logic [31:0] CP_REPLACE = 32'h0000_FFFD;
   localparam logic [31:0] CP_SUPP_BASE = 32'h0001_0000;
   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST = 16'hDC00;
   localparam logic [15:0] LOW_LAST = 16'hDFFF;
   localparam logic [7:0] LEAD2 = 8'hC0;
   localparam logic [7:0] LEAD3 = 8'hE0;
   localparam logic [7:0] LEAD4 = 8'hF0;
   localparam logic [7:0] CONT = 8'h80;
   localparam logic [7:0] REPL_B0 = 8'hEF;
   localparam logic [7:0] REPL_B1 = 8'hBF;
   localparam logic [7:0] REPL_B2 = 8'hBD;

   // Up to four bytes of one code point, first byte at index 0.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [CountW-1:0] count;
   } enc_type;

   // One queue entry: all bytes that one item causes.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountW-1:0] count;
   } entry_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Encode one code point; invalid values become the replacement character.
   function automatic enc_type encode(input logic [31:0] value);
      enc_type r;
      logic [20:0] c;
      r = '0;
      if (value > CP_MAX || (value >= SURR_FIRST && value <= SURR_LAST)) begin
         c = CP_REPLACE[20:0];
      end else begin
         c = value[20:0];
      end
      if (c < 21'h80) begin
         r.bytes[0] = {1'b0, c[6:0]};
         r.count = 3'd1;
      end else if (c < 21'h800) begin
         r.bytes[0] = LEAD2 | {3'b000, c[10:6]};
         r.bytes[1] = CONT | {2'b00, c[5:0]};
         r.count = 3'd2;
      end else if (c < 21'h10000) begin
         r.bytes[0] = LEAD3 | {4'b0000, c[15:12]};
         r.bytes[1] = CONT | {2'b00, c[11:6]};
         r.bytes[2] = CONT | {2'b00, c[5:0]};
         r.count = 3'd3;
      end else begin
         r.bytes[0] = LEAD4 | {5'b00000, c[20:18]};
         r.bytes[1] = CONT | {2'b00, c[17:12]};
         r.bytes[2] = CONT | {2'b00, c[11:6]};
         r.bytes[3] = CONT | {2'b00, c[5:0]};
         r.count = 3'd4;
      end
      return r;
   endfunction

endpackage

### sv/utf8enc_front.sv
// Front end: accepts code units, pairs surrogates and encodes each item into bytes.
module utf8enc_front import utf8enc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  qstat_type   qstat,
   output logic        push,
   output entry_type   push_entry
);

   logic        mode_ff, mode_in;
   logic        held_ff, held_in;
   logic [15:0] hi_ff, hi_in;

   logic        accept;
   logic [15:0] u16;
   logic        is_low, is_high;
   logic        prefix, hold;
   logic [31:0] arg;
   enc_type     enc;

   assign req_tready = !qstat.full;
   assign accept = req_tvalid && req_tready;
   assign u16 = req_tdata[15:0];
   assign is_low = (u16 >= LOW_FIRST) && (u16 <= LOW_LAST);
   assign is_high = (u16 >= HIGH_FIRST) && (u16 <= HIGH_LAST);

   // Classify the item and pick the code point to encode.
   always_comb begin
      prefix = 1'b0;
      hold = 1'b0;
      arg = req_tdata;
      if (!mode_ff) begin
         if (held_ff && is_low) begin
            arg = CP_SUPP_BASE + {12'b0, hi_ff[9:0], u16[9:0]};
         end else begin
            prefix = held_ff;
            hold = is_high && !req_tlast;
            arg = {16'b0, u16};
         end
      end
      enc = encode(arg);
   end

   // Build the queue entry, with the replacement bytes first for an unpaired high half.
   always_comb begin
      push_entry = '0;
      if (prefix) begin
         push_entry.bytes[0] = REPL_B0;
         push_entry.bytes[1] = REPL_B1;
         push_entry.bytes[2] = REPL_B2;
         if (!hold) begin
            push_entry.bytes[3] = enc.bytes[0];
            push_entry.bytes[4] = enc.bytes[1];
            push_entry.bytes[5] = enc.bytes[2];
            push_entry.count = 3'd3 + enc.count;
         end else begin
            push_entry.count = 3'd3;
         end
      end else if (!hold) begin
         push_entry.bytes[3:0] = enc.bytes;
         push_entry.count = enc.count;
      end
      push = accept && (push_entry.count != '0);
   end

   // Next value of the mode register and of the held surrogate.
   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      hi_in = hi_ff;
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
         held_in = 1'b0;
      end else if (accept) begin
         held_in = hold;
         if (hold) begin
            hi_in = u16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         held_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
      hi_ff <= hi_in;
   end

endmodule

### sv/utf8enc_queue.sv
// Two-entry queue of encoded items between the front and the back.
module utf8enc_queue import utf8enc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output qstat_type qstat
);

   entry_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign qstat.full = (count_ff == 2'd2);
   assign qstat.empty = (count_ff == 2'd0);
   assign head = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/utf8enc_back.sv
// Back end: sends the bytes of the head queue entry one per cycle while rsp_tready is high.
module utf8enc_back import utf8enc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  qstat_type qstat,
   output logic      pop,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic      rsp_tlast
);

   logic [CountW-1:0] idx_ff, idx_in;
   logic              take;

   assign rsp_tvalid = !qstat.empty;
   assign rsp_tlast = (idx_ff == head.count - 3'd1);
   assign take = rsp_tvalid && rsp_tready;
   assign pop = take && rsp_tlast;

   // Byte select from the head entry.
   always_comb begin
      unique case (idx_ff)
         3'd0: rsp_tdata = head.bytes[0];
         3'd1: rsp_tdata = head.bytes[1];
         3'd2: rsp_tdata = head.bytes[2];
         3'd3: rsp_tdata = head.bytes[3];
         3'd4: rsp_tdata = head.bytes[4];
         3'd5: rsp_tdata = head.bytes[5];
         default: rsp_tdata = '0;
      endcase
   end

   // Byte index steps on each item taken and restarts on the last byte.
   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

### sv/utf16_utf32_to_utf8_encoder_top.sv
// An accepted item's bytes are registered in the queue and offered by the back end.
// One byte per cycle leaves while rsp_tready is high; an item of n bytes (0 to 6) holds
// the back end until its last byte is taken, while the front accepts one item per cycle
// as long as the two-entry queue has room, so bytes per item set the sustained rate.
// Reset (synchronous) empties the queue, drops a held surrogate and selects 16-bit mode.
module utf16_utf32_to_utf8_encoder_top import utf8enc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,   // unit_width_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [31:0] code_unit
   input  logic        req_tlast,     // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // [7:0] out_byte
   output logic        rsp_tlast      // last_of_run
);

   qstat_type qstat;
   logic      push, pop;
   entry_type push_entry, head;

   utf8enc_front u_front (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .qstat(qstat), .push(push), .push_entry(push_entry)
   );

   utf8enc_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_entry(push_entry),
      .pop(pop), .head(head), .qstat(qstat)
   );

   utf8enc_back u_back (
      .clock(clock), .reset(reset),
      .head(head), .qstat(qstat), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

endmodule

### sv/utf8enc_checker.sv
// Port-level checks of the UTF-8 encoder and their binding to the top level.
module utf8enc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled output item stays offered.
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // A stalled output item keeps its payload.
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // The final byte of an item is never a lead byte of a multi-byte sequence.
   a_last_not_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:6] != 2'b11)
      else $error("lead byte marked as last");

   // A byte that is not the final one belongs to a multi-byte sequence.
   a_inner_not_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[7])
      else $error("single-byte character not marked as last");

endmodule

bind utf16_utf32_to_utf8_encoder_top utf8enc_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);

### dv/utf16_utf32_to_utf8_encoder_top_tb.sv
// Self-checking testbench for the UTF-16/UTF-32 to UTF-8 encoder top level.
module utf16_utf32_to_utf8_encoder_top_tb;

   localparam logic MODE_UTF16 = 1'b0;
   localparam logic MODE_UTF32 = 1'b1;

   localparam logic [31:0] CODE_MAX = 32'h0010_FFFF;
   localparam logic [31:0] REPLACEMENT = 32'h0000_FFFD;
   localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
   localparam logic [15:0] HI_SURR_LAST = 16'hDBFF;
   localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
   localparam logic [15:0] LO_SURR_LAST = 16'hDFFF;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 150;

   // One output byte with its end-of-item flag.
   typedef struct packed {
      logic [7:0] value;
      logic last;
   } utf8_byte_type;

   // Tracks the width mode and the pending high surrogate, and queues the
   // bytes that each accepted code unit must produce.
   class utf8_stream_model_type;
      logic wide_mode;
      logic [15:0] held_high;
      logic have_high;
      logic [7:0] staged[$];
      utf8_byte_type pending[$];
      int errors;
      int units_taken;
      int bytes_seen;
      int pairs_joined;
      int replaced;
      int mode_writes;

      function new();
         wide_mode = MODE_UTF16;
         held_high = '0;
         have_high = 1'b0;
         errors = 0;
         units_taken = 0;
         bytes_seen = 0;
         pairs_joined = 0;
         replaced = 0;
         mode_writes = 0;
      endfunction

      // A mode write always drops a pending high surrogate.
      function void set_mode(logic mode);
         wide_mode = mode;
         have_high = 1'b0;
         held_high = '0;
         mode_writes++;
      endfunction

      // Add one byte at the end of the staged bytes.
      function void add_byte(logic [7:0] b);
         staged.insert(staged.size(), b);
      endfunction

      // Append the UTF-8 form of one code point to the staged bytes.
      function void append_code_point(logic [31:0] cp);
         logic [20:0] c;
         if (cp > CODE_MAX || (cp >= 32'(HI_SURR_FIRST) && cp <= 32'(LO_SURR_LAST))) begin
            c = REPLACEMENT[20:0];
         end else begin
            c = cp[20:0];
         end
         if (c == REPLACEMENT[20:0]) begin
            replaced++;
         end
         if (c < 21'h80) begin
            add_byte({1'b0, c[6:0]});
         end else if (c < 21'h800) begin
            add_byte({3'b110, c[10:6]});
            add_byte({2'b10, c[5:0]});
         end else if (c < 21'h10000) begin
            add_byte({4'b1110, c[15:12]});
            add_byte({2'b10, c[11:6]});
            add_byte({2'b10, c[5:0]});
         end else begin
            add_byte({5'b11110, c[20:18]});
            add_byte({2'b10, c[17:12]});
            add_byte({2'b10, c[11:6]});
            add_byte({2'b10, c[5:0]});
         end
      endfunction

      // Note one accepted code unit and queue the bytes it causes.
      function void take_unit(logic [31:0] unit, logic eos);
         logic [15:0] u16;
         logic is_low;
         logic is_high;
         logic joined;
         utf8_byte_type entry;
         staged.delete();
         units_taken++;
         joined = 1'b0;
         if (wide_mode == MODE_UTF32) begin
            append_code_point(unit);
         end else begin
            u16 = unit[15:0];
            is_low = (u16 >= LO_SURR_FIRST) && (u16 <= LO_SURR_LAST);
            is_high = (u16 >= HI_SURR_FIRST) && (u16 <= HI_SURR_LAST);
            if (have_high) begin
               have_high = 1'b0;
               if (is_low) begin
                  // Ten bits from each half on top of the supplementary base.
                  append_code_point(32'h0001_0000 + {12'h000, held_high[9:0], u16[9:0]});
                  pairs_joined++;
                  joined = 1'b1;
               end else begin
                  append_code_point(REPLACEMENT);
               end
               held_high = '0;
            end
            if (!joined) begin
               if (is_high && !eos) begin
                  held_high = u16;
                  have_high = 1'b1;
               end else begin
                  append_code_point({16'h0000, u16});
               end
            end
         end
         foreach (staged[i]) begin
            entry.value = staged[i];
            entry.last = (i == staged.size() - 1);
            pending.insert(pending.size(), entry);
         end
      endfunction

      // Compare one accepted output byte with the oldest queued byte.
      function void match_byte(logic [7:0] value, logic last);
         utf8_byte_type want;
         if (pending.size() == 0) begin
            $display("%0t: byte %02h last %0b arrived with nothing outstanding",
                     $time, value, last);
            errors++;
            return;
         end
         want = pending.pop_front();
         bytes_seen++;
         if (want.value !== value) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want.value, value);
            errors++;
         end
         if (want.last !== last) begin
            $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                     $time, want.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   utf8_stream_model_type model;
   int send_idle_pct;
   int recv_stall_pct;
   logic hold_off;
   int quiet_cycles;

   utf16_utf32_to_utf8_encoder_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Output side: random back-pressure, or a forced hold-off.
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check every accepted byte and watch for a stuck block.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            model.match_byte(rsp_tdata, rsp_tlast);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d bytes still outstanding",
                     $time, QUIET_LIMIT, model.outstanding());
            $display("utf16_utf32_to_utf8_encoder_top_tb: errors");
            $finish;
         end
      end
   end

   // Offer one code unit, idling first at the current rate, and wait until it is taken.
   task automatic send_unit(input logic [31:0] unit, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= $urandom();
         req_tlast <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= unit;
      req_tlast <= eos;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      model.take_unit(unit, eos);
   endtask

   task automatic write_unit_mode(input logic mode);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model.set_mode(mode);
   endtask

   // Wait for every queued byte, then let a held unit settle inside the block.
   task automatic wait_drained();
      while (model.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic hold_receiver(input int cycles);
      hold_off <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_off <= 1'b0;
   endtask

   function automatic logic random_eos();
      return ($urandom_range(5) == 0);
   endfunction

   // Mostly well-formed UTF-16 text with some broken surrogate use and noise.
   task automatic send_utf16_mix(input int count);
      int sent;
      int pick;
      logic [31:0] upper;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         upper = ($urandom_range(1) == 1) ? ($urandom() & 32'hFFFF_0000) : 32'h0;
         if (pick < 20) begin
            send_unit(upper | $urandom_range(32'h7F), random_eos());
         end else if (pick < 35) begin
            send_unit(upper | $urandom_range(32'h80, 32'h7FF), random_eos());
         end else if (pick < 50) begin
            if ($urandom_range(1) == 1) begin
               send_unit(upper | $urandom_range(32'h800, 32'hD7FF), random_eos());
            end else begin
               send_unit(upper | $urandom_range(32'hE000, 32'hFFFF), random_eos());
            end
         end else if (pick < 78) begin
            // Proper surrogate pair.
            send_unit(upper | $urandom_range(HI_SURR_FIRST, HI_SURR_LAST), 1'b0);
            send_unit(($urandom() & 32'hFFFF_0000) |
                      $urandom_range(LO_SURR_FIRST, LO_SURR_LAST), random_eos());
            sent++;
         end else if (pick < 84) begin
            send_unit(upper | $urandom_range(LO_SURR_FIRST, LO_SURR_LAST), random_eos());
         end else if (pick < 92) begin
            // High surrogate that may end the string or be followed by anything.
            send_unit(upper | $urandom_range(HI_SURR_FIRST, HI_SURR_LAST), random_eos());
         end else begin
            send_unit($urandom(), random_eos());
         end
         sent++;
      end
      req_tvalid <= 1'b0;
   endtask

   // Code points of every length, surrogate values and out-of-range values.
   task automatic send_utf32_mix(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            send_unit($urandom_range(32'h7F), random_eos());
         end else if (pick < 30) begin
            send_unit($urandom_range(32'h80, 32'h7FF), random_eos());
         end else if (pick < 50) begin
            send_unit($urandom_range(32'h800, 32'hFFFF), random_eos());
         end else if (pick < 70) begin
            send_unit($urandom_range(32'h1_0000, CODE_MAX), random_eos());
         end else if (pick < 80) begin
            send_unit($urandom_range(HI_SURR_FIRST, LO_SURR_LAST), random_eos());
         end else if (pick < 90) begin
            send_unit($urandom_range(32'h11_0000, 32'hFFFF_FFFF), random_eos());
         end else begin
            send_unit($urandom(), random_eos());
         end
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic run_phase(input logic mode, input int idle_pct, input int stall_pct,
                            input int count);
      wait_drained();
      write_unit_mode(mode);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      if (mode == MODE_UTF32) begin
         send_utf32_mix(count);
      end else begin
         send_utf16_mix(count);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      quiet_cycles = 0;
      model = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed UTF-16 cases in the reset mode: length boundaries first.
      send_unit(32'h0000_0000, 1'b0);
      send_unit(32'h0000_007F, 1'b0);
      send_unit(32'h0000_0080, 1'b0);
      send_unit(32'h0000_07FF, 1'b0);
      send_unit(32'h0000_0800, 1'b0);
      send_unit(32'hFFFF_FFFF, 1'b1);
      // Lowest and highest surrogate pairs.
      send_unit(32'h0000_D800, 1'b0);
      send_unit(32'h0000_DC00, 1'b0);
      send_unit(32'h0000_DBFF, 1'b0);
      send_unit(32'h0000_DFFF, 1'b1);
      // Lone low, high followed by a plain unit, high followed by a high that ends
      // the string, and a high then a three-byte unit for the six-byte case.
      send_unit(32'h0000_DC00, 1'b1);
      send_unit(32'h0000_D834, 1'b0);
      send_unit(32'hFFFF_0041, 1'b0);
      send_unit(32'h0000_D800, 1'b0);
      send_unit(32'h0000_DBFF, 1'b1);
      send_unit(32'h0000_DABC, 1'b0);
      send_unit(32'h0000_0800, 1'b1);
      // A held high surrogate is dropped silently by a mode write.
      send_unit(32'h0000_D800, 1'b0);
      req_tvalid <= 1'b0;
      wait_drained();
      write_unit_mode(MODE_UTF16);
      send_unit(32'h0000_DC00, 1'b1);
      req_tvalid <= 1'b0;
      wait_drained();

      // Directed UTF-32 cases: range ends, surrogates and oversized values.
      write_unit_mode(MODE_UTF32);
      send_unit(32'h0000_0000, 1'b0);
      send_unit(32'h0000_FFFF, 1'b0);
      send_unit(32'h0001_0000, 1'b0);
      send_unit(32'h0010_FFFF, 1'b0);
      send_unit(32'h0011_0000, 1'b0);
      send_unit(32'h0000_D800, 1'b0);
      send_unit(32'h0000_DFFF, 1'b0);
      send_unit(32'hFFFF_FFFF, 1'b1);
      req_tvalid <= 1'b0;

      // Random phases across both widths and all idling patterns.
      run_phase(MODE_UTF16, 0, 0, 60);
      run_phase(MODE_UTF32, 70, 0, 50);
      run_phase(MODE_UTF16, 0, 70, 60);
      run_phase(MODE_UTF32, 33, 33, 50);
      run_phase(MODE_UTF16, 33, 33, 60);

      // Output held off for a long stretch while input keeps coming.
      wait_drained();
      write_unit_mode(MODE_UTF16);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      fork
         hold_receiver(HOLD_OFF_CYCLES);
         send_utf16_mix(50);
      join

      run_phase(MODE_UTF32, 0, 0, 50);
      wait_drained();

      if (model.outstanding() != 0) begin
         $display("%0t: %0d bytes never arrived", $time, model.outstanding());
         model.errors++;
      end
      $display("Covered %0d code units giving %0d bytes in %0d mode settings,",
               model.units_taken, model.bytes_seen, model.mode_writes);
      $display("with %0d joined surrogate pairs and %0d replacement characters.",
               model.pairs_joined, model.replaced);
      if (model.errors == 0) begin
         $display("utf16_utf32_to_utf8_encoder_top_tb: clean");
      end else begin
         $display("utf16_utf32_to_utf8_encoder_top_tb: errors");
      end
      $finish;
   end

endmodule
